@@ hdl/drfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Display reply frame parser package
// Phase codes, frame constants and the result record shared by the parser
// core and the top level.
// ----------------------------------------------------------------------------
package drfp_pkg;

	// Frame header and command bytes.
	localparam logic [7:0] HDR_FIRST  = 8'h5A;
	localparam logic [7:0] HDR_SECOND = 8'hA5;
	localparam logic [7:0] CMD_REG_RD = 8'h81;
	localparam logic [7:0] CMD_VAR_WR = 8'h82;
	localparam logic [7:0] CMD_VAR_RD = 8'h83;

	// Number of body bytes that make up one variable-read result.
	localparam logic [7:0] BODY_NEED = 8'd5;
	// Body bytes held in registers; the last one is taken straight from the input.
	localparam int BODY_HELD = 4;
	localparam int BODY_IDX_W = $clog2(BODY_HELD);

	// Parse phase codes.
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LEN   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_CMD   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_VAR   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd5;

	// One parsed variable-read reply.
	typedef struct packed {
		logic        valid;
		logic [15:0] var_address;
		logic [7:0]  word_count;
		logic [15:0] first_word;
	} drfp_result_t;

	// Parser status toward the top level.
	typedef struct packed {
		logic last_body;   // the next accepted byte completes a result
	} drfp_status_t;

endpackage

@@ hdl/drfp_parser.sv @@
// ----------------------------------------------------------------------------
// Display reply frame parser core
// Header hunt, length and command decode, body capture and skip. Produces a
// result in the same cycle as the fifth body byte of a variable-read reply.
// ----------------------------------------------------------------------------
module drfp_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             rx_byte,
	output drfp_pkg::drfp_result_t result,
	output drfp_pkg::drfp_status_t status
);
	import drfp_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_next;
	logic [7:0]         frame_length_q;
	logic [7:0]         body_count_q;
	logic [7:0]         count_inc;
	logic [7:0]         len_m1;
	logic [7:0]         body_q [BODY_HELD];
	logic               emit;

	assign count_inc = body_count_q + 8'd1;
	assign len_m1    = frame_length_q - 8'd1;
	assign emit      = (phase_q == PH_VAR) && (count_inc == BODY_NEED);

	always_comb begin
		phase_next = PH_HUNT1;
		unique case (phase_q)
			PH_HUNT2: begin
				phase_next = (rx_byte == HDR_SECOND) ? PH_LEN : PH_HUNT1;
			end
			PH_LEN: begin
				phase_next = PH_CMD;
			end
			PH_CMD: begin
				if (frame_length_q <= 8'd1) begin
					phase_next = PH_HUNT1;
				end else if (rx_byte == CMD_VAR_RD) begin
					phase_next = PH_VAR;
				end else if (rx_byte == CMD_VAR_WR || rx_byte == CMD_REG_RD) begin
					phase_next = PH_SKIP;
				end else begin
					phase_next = PH_HUNT1;
				end
			end
			PH_VAR: begin
				if (emit || count_inc >= len_m1) begin
					phase_next = PH_HUNT1;
				end else begin
					phase_next = PH_VAR;
				end
			end
			PH_SKIP: begin
				phase_next = (count_inc >= len_m1) ? PH_HUNT1 : PH_SKIP;
			end
			default: begin
				phase_next = (rx_byte == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT1;
			frame_length_q <= 8'd0;
			body_count_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_next;
			if (phase_q == PH_LEN) begin
				frame_length_q <= rx_byte;
			end
			if (phase_q == PH_CMD) begin
				body_count_q <= 8'd0;
			end else if (phase_q == PH_VAR || phase_q == PH_SKIP) begin
				body_count_q <= count_inc;
			end
		end
	end

	// Body capture; the count stays below five while collecting a reply.
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_VAR && !emit) begin
			body_q[body_count_q[BODY_IDX_W-1:0]] <= rx_byte;
		end
	end

	assign result.valid       = accept && emit;
	assign result.var_address = {body_q[0], body_q[1]};
	assign result.word_count  = body_q[2];
	assign result.first_word  = {body_q[3], rx_byte};

	assign status.last_body = (phase_q == PH_VAR) && (body_count_q == BODY_NEED - 8'd1);

	// While collecting a reply the count never reaches the result size.
	a_var_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VAR) |-> (body_count_q < BODY_NEED))
		else $error("body count out of range while collecting a reply");

	// A result always sends the parser back to the header hunt.
	a_emit_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> (phase_q == PH_HUNT1))
		else $error("parser did not return to header hunt after a result");

	// Only defined phase codes are ever reached.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_SKIP)
		else $error("parser reached an unused phase code");

endmodule

@@ hdl/display_reply_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Display reply frame parser
// Receives serial bytes from a display link, finds 0x5A 0xA5 framed replies
// and reports address, word count and first data word of variable reads.
// ----------------------------------------------------------------------------
// The block takes one received byte per request on the rx channel and accepts
// a byte in every clock cycle in which rx_stall is low. Each byte is decoded
// in the cycle it arrives; the fifth body byte of a variable-read reply
// (command 0x83) completes a result, which is held in an output register and
// offered on the res channel from the next cycle on. Write acknowledgements
// (0x82) and register-read replies (0x81) are skipped over length-1 body
// bytes, unknown commands and short variable-read replies return to the
// header hunt and report nothing. The rx channel stalls only when the byte
// that would complete a new result is due while the previous result is
// still held by a stalled res channel; every other byte is taken even while
// a result waits.
// ----------------------------------------------------------------------------
module display_reply_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] var_address,
	output logic [7:0]  word_count,
	output logic [15:0] first_word
);
	import drfp_pkg::*;

	drfp_result_t result;
	drfp_status_t status;
	logic         rx_accept;
	logic         res_valid_q;
	logic [15:0]  var_address_q;
	logic [7:0]   word_count_q;
	logic [15:0]  first_word_q;

	// Hold off the completing byte only while an older result is stuck.
	assign rx_stall  = res_valid_q && res_stall && status.last_body;
	assign rx_accept = rx_valid && !rx_stall;

	drfp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (rx_accept),
		.rx_byte(rx_byte),
		.result (result),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (result.valid) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			var_address_q <= result.var_address;
			word_count_q  <= result.word_count;
			first_word_q  <= result.first_word;
		end
	end

	assign res_valid   = res_valid_q;
	assign var_address = var_address_q;
	assign word_count  = word_count_q;
	assign first_word  = first_word_q;

	// A new result never lands on a held one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !result.valid)
		else $error("result overwrote a stalled output");

	// A result is only produced by an accepted byte.
	a_result_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> rx_accept)
		else $error("result without an accepted byte");

	// A result produced in one cycle is offered in the next.
	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> res_valid_q)
		else $error("produced result was not offered");

endmodule
